// ===== rtl/md4_hash_engine_defines.svh =====
// Assertion macros for the MD4 hash engine.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MD4_HASH_ENGINE_DEFINES_SVH
`define MD4_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MD4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MD4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/md4_pkg.sv =====
// Shared types, constants and helper functions for the MD4 hash engine.
// No dependencies; imported by md4_hash_engine and md4_core.
`default_nettype none

package md4_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md4_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
  } md4_out_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_R2 = 32'h5A827999;
  localparam logic [31:0] K_R3 = 32'h6ED9EBA1;

  // Byte slot where the length field starts (448 bits into a 512-bit block).
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [1:0] RND_1 = 2'd0;
  localparam logic [1:0] RND_2 = 2'd1;
  localparam logic [1:0] RND_3 = 2'd2;

  function automatic logic [4:0] shift_amt(input logic [1:0] rnd, input logic [1:0] lane);
    logic [4:0] s;
    s = 5'd3;
    case (rnd)
      RND_1: begin
        case (lane)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      RND_2: begin
        case (lane)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (lane)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // Message word order: plain, transposed 4x4, then bit-reversed.
  function automatic logic [3:0] msg_index(input logic [1:0] rnd, input logic [3:0] step);
    logic [3:0] idx;
    case (rnd)
      RND_1:   idx = step;
      RND_2:   idx = {step[1:0], step[3:2]};
      default: idx = {step[0], step[1], step[2], step[3]};
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/md4_hash_engine.sv =====
// MD4 hash engine top level: input FIFO, MD4 core, output FIFO.
// Depends on md4_pkg, md4_fifo, md4_core and md4_hash_engine_defines.svh.
`default_nettype none
`include "md4_hash_engine_defines.svh"

// Computes the MD4 digest of a byte stream, one byte per input word. A word
// with end_of_message set (with or without a byte) finishes the message and
// yields four result words, A to D, with last_word set on D; the engine then
// starts afresh. Input words queue in an IN_DEPTH entry FIFO and the core
// absorbs one byte per cycle while idle. Every 64th byte stops intake while
// the single round unit runs the 48 MD4 steps, one per cycle, and adds the
// result into the chaining value. Finishing writes the padding and length
// bytes (9 to 72 bytes), compresses each block so completed, then pushes the
// digest words into the OUT_DEPTH entry result FIFO as it has room.
module md4_hash_engine
  import md4_pkg::*;
#(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire md4_in_t  in_item,
  output logic          empty,
  input  wire logic     pop,
  output md4_out_t      out_item
);

  md4_in_t  in_q_word;
  logic     in_q_empty;
  logic     core_pop;
  md4_out_t core_word;
  logic     out_q_full;
  logic     core_push;

  md4_fifo #(
    .WIDTH($bits(md4_in_t)),
    .DEPTH(IN_DEPTH)
  ) u_in_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(in_item),
    .full   (full),
    .rd_en  (core_pop),
    .rd_data(in_q_word),
    .empty  (in_q_empty)
  );

  md4_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_q_word),
    .in_empty(in_q_empty),
    .in_pop  (core_pop),
    .out_word(core_word),
    .out_full(out_q_full),
    .out_push(core_push)
  );

  md4_fifo #(
    .WIDTH($bits(md4_out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (core_push),
    .wr_data(core_word),
    .full   (out_q_full),
    .rd_en  (pop),
    .rd_data(out_item),
    .empty  (empty)
  );

  `MD4_ASSERT_NOW(a_pop_needs_word, core_pop, !in_q_empty, "core popped an empty input FIFO")
  `MD4_ASSERT_NOW(a_push_needs_room, core_push, !out_q_full, "core pushed into a full result FIFO")
  `MD4_ASSERT_NOW(a_last_is_d, core_push, core_word.last_word == (core_word.word_number == 2'd3), "last_word not on word D")
  `MD4_ASSERT_NEXT(a_no_intake_after_d, core_push && core_word.last_word, !core_push, "digest word pushed after word D")

endmodule

`default_nettype wire

// ===== rtl/md4_fifo.sv =====
// Small register-based FIFO used on both sides of the MD4 core.
// Depends on nothing but its parameters.
`default_nettype none

module md4_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/md4_core.sv =====
// MD4 back end: block buffer, padding sequencer, shared round unit, digest output.
// Depends on md4_pkg; fed from the input FIFO, feeds the output FIFO.
`default_nettype none

module md4_core
  import md4_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire md4_in_t  in_word,
  input  wire logic     in_empty,
  output logic          in_pop,
  output md4_out_t      out_word,
  input  wire logic     out_full,
  output logic          out_push
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] PK_FIRST = 2'd0;
  localparam logic [1:0] PK_ZERO  = 2'd1;
  localparam logic [1:0] PK_LEN   = 2'd2;

  localparam logic [5:0] LAST_STEP = 6'd48;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] blk_r [16];
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] va_r, vb_r, vc_r, vd_r;
  logic [31:0] va_nxt, vb_nxt, vc_nxt, vd_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        pad_on_r, pad_on_nxt;
  logic [1:0]  pad_kind_r, pad_kind_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic        pad_done_r, pad_done_nxt;
  logic [1:0]  wcnt_r, wcnt_nxt;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [5:0]  pos_inc;
  logic        wrap;

  logic [1:0]  rnd;
  logic [31:0] f_val, w_val, k_val, sum, rot;
  logic [4:0]  s_amt;

  // Round unit: one MD4 step per cycle on the rotating a/b/c/d registers.
  always_comb begin
    rnd   = step_r[5:4];
    case (rnd)
      RND_1:   f_val = (vb_r & vc_r) | (~vb_r & vd_r);
      RND_2:   f_val = (vb_r & vc_r) | (vb_r & vd_r) | (vc_r & vd_r);
      default: f_val = vb_r ^ vc_r ^ vd_r;
    endcase
    case (rnd)
      RND_1:   k_val = '0;
      RND_2:   k_val = K_R2;
      default: k_val = K_R3;
    endcase
    w_val = blk_r[msg_index(rnd, step_r[3:0])];
    s_amt = shift_amt(rnd, step_r[1:0]);
    sum   = va_r + f_val + w_val + k_val;
    rot   = rotl32(sum, s_amt);
  end

  assign pos_inc  = pos_r + 6'd1;
  assign wrap     = wr_en && (pos_r == 6'd63);
  assign out_word = '{digest_word: chain_r[wcnt_r],
                      word_number: wcnt_r,
                      last_word:   (wcnt_r == 2'd3)};

  always_comb begin
    state_nxt    = state_r;
    bitlen_nxt   = bitlen_r;
    pos_nxt      = pos_r;
    va_nxt       = va_r;
    vb_nxt       = vb_r;
    vc_nxt       = vc_r;
    vd_nxt       = vd_r;
    step_nxt     = step_r;
    pad_on_nxt   = pad_on_r;
    pad_kind_nxt = pad_kind_r;
    len_idx_nxt  = len_idx_r;
    pad_done_nxt = pad_done_r;
    wcnt_nxt     = wcnt_r;
    for (int i = 0; i < 4; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    in_pop   = 1'b0;
    out_push = 1'b0;
    wr_en    = 1'b0;
    wr_byte  = in_word.data_byte;

    case (state_r)
      S_IDLE: begin
        in_pop = ~in_empty;
        if (!in_empty) begin
          if (in_word.has_byte) begin
            wr_en      = 1'b1;
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_word.end_of_message) begin
            pad_on_nxt   = 1'b1;
            pad_kind_nxt = PK_FIRST;
            len_idx_nxt  = '0;
            pad_done_nxt = 1'b0;
            state_nxt    = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en = 1'b1;
        case (pad_kind_r)
          PK_FIRST: wr_byte = 8'h80;
          PK_ZERO:  wr_byte = 8'h00;
          default:  wr_byte = bitlen_r[{len_idx_r, 3'b000} +: 8];
        endcase
        if (pad_kind_r == PK_LEN) begin
          len_idx_nxt = len_idx_r + 3'd1;
          if (len_idx_r == 3'd7) begin
            pad_done_nxt = 1'b1;
          end
        end else begin
          pad_kind_nxt = (pos_inc == LEN_POS) ? PK_LEN : PK_ZERO;
        end
      end
      S_COMP: begin
        if (step_r != LAST_STEP) begin
          va_nxt   = vd_r;
          vb_nxt   = rot;
          vc_nxt   = vb_r;
          vd_nxt   = vc_r;
          step_nxt = step_r + 6'd1;
        end else begin
          chain_nxt[0] = chain_r[0] + va_r;
          chain_nxt[1] = chain_r[1] + vb_r;
          chain_nxt[2] = chain_r[2] + vc_r;
          chain_nxt[3] = chain_r[3] + vd_r;
          wcnt_nxt     = '0;
          if (pad_done_r) begin
            state_nxt = S_OUT;
          end else if (pad_on_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        out_push = ~out_full;
        if (!out_full) begin
          wcnt_nxt = wcnt_r + 2'd1;
          if (wcnt_r == 2'd3) begin
            // Digest delivered: return to the initial chaining value.
            chain_nxt[0] = IV_A;
            chain_nxt[1] = IV_B;
            chain_nxt[2] = IV_C;
            chain_nxt[3] = IV_D;
            bitlen_nxt   = '0;
            pad_on_nxt   = 1'b0;
            pad_done_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
    endcase

    if (wr_en) begin
      pos_nxt = pos_inc;
    end
    // A full block preempts the next state: compress, then resume.
    if (wrap) begin
      state_nxt = S_COMP;
      step_nxt  = '0;
      va_nxt    = chain_r[0];
      vb_nxt    = chain_r[1];
      vc_nxt    = chain_r[2];
      vd_nxt    = chain_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
      bitlen_r   <= '0;
      pos_r      <= '0;
      step_r     <= '0;
      pad_on_r   <= 1'b0;
      pad_kind_r <= PK_FIRST;
      len_idx_r  <= '0;
      pad_done_r <= 1'b0;
      wcnt_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      chain_r    <= chain_nxt;
      bitlen_r   <= bitlen_nxt;
      pos_r      <= pos_nxt;
      step_r     <= step_nxt;
      pad_on_r   <= pad_on_nxt;
      pad_kind_r <= pad_kind_nxt;
      len_idx_r  <= len_idx_nxt;
      pad_done_r <= pad_done_nxt;
      wcnt_r     <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r <= va_nxt;
    vb_r <= vb_nxt;
    vc_r <= vc_nxt;
    vd_r <= vd_nxt;
  end

  // Little-endian packing; the first byte of a word clears the rest of it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (pos_r[1:0] == 2'd0) begin
        blk_r[pos_r[5:2]] <= {24'd0, wr_byte};
      end else begin
        blk_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= wr_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/md4_hash_engine_test.sv =====
// Self-checking testbench for md4_hash_engine: byte messages in, four digest words out.
// Uses the md4_pkg word types. Expected digests come from an MD4 model kept in this file.
`timescale 1ns / 100ps

module md4_hash_engine_test;
  import md4_pkg::*;

  localparam int TARGET_BYTES = 420;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 250;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C   = 32'h98BADCFE;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] MAJ_K    = 32'h5A827999;
  localparam logic [31:0] PARITY_K = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_SLOT = 6'd56;

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  md4_in_t  in_item;
  logic     empty;
  logic     pop;
  md4_out_t out_item;

  md4_hash_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // Model state
  logic [31:0] chain_words [4];
  logic [31:0] block_buf [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;
  md4_out_t    digest_queue [$];

  int mismatches = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int rx_mode = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic int step_shift(input int rnd, input int lane);
    int s;
    case (rnd)
      0:       s = (lane == 0) ? 3 : (lane == 1) ? 7 : (lane == 2) ? 11 : 19;
      1:       s = (lane == 0) ? 3 : (lane == 1) ? 5 : (lane == 2) ? 9 : 13;
      default: s = (lane == 0) ? 3 : (lane == 1) ? 9 : (lane == 2) ? 11 : 15;
    endcase
    return s;
  endfunction

  function automatic void clear_chain();
    chain_words[0] = INIT_A;
    chain_words[1] = INIT_B;
    chain_words[2] = INIT_C;
    chain_words[3] = INIT_D;
    msg_bits = 64'd0;
    fill_pos = 6'd0;
  endfunction

  function automatic void md4_compress_block();
    logic [31:0] v [4];
    logic [31:0] f, k, w, x, y, z;
    logic [3:0]  st;
    int t;
    for (int i = 0; i < 4; i++) v[i] = chain_words[i];
    for (int i = 0; i < 48; i++) begin
      t  = (4 - (i % 4)) % 4;
      st = 4'(i % 16);
      x  = v[(t + 1) % 4];
      y  = v[(t + 2) % 4];
      z  = v[(t + 3) % 4];
      if (i < 16) begin
        f = (x & y) | (~x & z);
        k = 32'd0;
        w = block_buf[st];
      end else if (i < 32) begin
        f = (x & y) | (x & z) | (y & z);
        k = MAJ_K;
        w = block_buf[{st[1:0], st[3:2]}];
      end else begin
        f = x ^ y ^ z;
        k = PARITY_K;
        w = block_buf[{st[0], st[1], st[2], st[3]}];
      end
      v[t] = rol32(v[t] + f + w + k, step_shift(i / 16, i % 4));
    end
    for (int i = 0; i < 4; i++) chain_words[i] = chain_words[i] + v[i];
  endfunction

  // Bytes pack little-endian; the first byte of each word overwrites it.
  function automatic void absorb_byte(input logic [7:0] b);
    int wi, sh;
    wi = fill_pos[5:2];
    sh = fill_pos[1:0] * 8;
    if (sh == 0) block_buf[wi] = {24'd0, b};
    else block_buf[wi] = block_buf[wi] | ({24'd0, b} << sh);
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) md4_compress_block();
  endfunction

  function automatic void predict_digest(input md4_in_t it);
    logic [63:0] len_bits;
    md4_out_t    word;
    if (it.has_byte) begin
      absorb_byte(it.data_byte);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.end_of_message) begin
      len_bits = msg_bits;
      absorb_byte(PAD_BYTE);
      while (fill_pos != LEN_SLOT) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len_bits[8*i +: 8]);
      for (int i = 0; i < 4; i++) begin
        word.digest_word = chain_words[i];
        word.word_number = 2'(i);
        word.last_word   = (i == 3);
        digest_queue.insert(digest_queue.size(), word);
      end
      clear_chain();
    end
  endfunction

  function automatic md4_in_t make_word(input logic [7:0] b, input logic hb, input logic eom);
    md4_in_t it;
    it.data_byte      = b;
    it.has_byte       = hb;
    it.end_of_message = eom;
    return it;
  endfunction

  task automatic sender_gap(input int n);
    @(negedge clk);
    push <= 1'b0;
    in_item <= make_word(8'($urandom), 1'($urandom), 1'($urandom));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_word(input md4_in_t it);
    if (gaps_on && burst_left == 0) begin
      sender_gap($urandom_range(1, 6));
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    predict_digest(it);
    if (it.has_byte || it.end_of_message) bytes_sent++;
  endtask

  // Hold the sender until every digest word in flight has come out.
  task automatic wait_for_digests();
    @(negedge clk);
    push <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic run_message(input int len, input bit end_on_byte, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_word(make_word(8'($urandom), 1'b0, 1'b0));
      send_word(make_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1)));
    end
    if (!end_on_byte || len == 0)
      send_word(make_word(8'($urandom), 1'b0, 1'b1));
  endtask

  task automatic test_directed_messages();
    // Empty message
    send_word(make_word(8'h5A, 1'b0, 1'b1));
    // "abc" with a stray word in the middle and a bare end
    send_word(make_word(8'h61, 1'b1, 1'b0));
    send_word(make_word(8'h62, 1'b1, 1'b0));
    send_word(make_word(8'hFF, 1'b0, 1'b0));
    send_word(make_word(8'h63, 1'b1, 1'b0));
    send_word(make_word(8'h00, 1'b0, 1'b1));
    // Single byte carried on the end word, both byte extremes
    send_word(make_word(8'h00, 1'b1, 1'b1));
    send_word(make_word(8'hFF, 1'b1, 1'b1));
    // Three bytes, last one with the end
    send_word(make_word(8'hAA, 1'b1, 1'b0));
    send_word(make_word(8'h55, 1'b1, 1'b0));
    send_word(make_word(8'h80, 1'b1, 1'b1));
    wait_for_digests();
  endtask

  task automatic test_block_boundaries();
    gaps_on = 1'b0;
    // Pad fits exactly in front of the length
    run_message(55, 1'b0, 0);
    gaps_on = 1'b1;
    // Pad overflows into a second block
    run_message(56, 1'b1, 5);
    // Full block, then a block of padding only
    run_message(64, 1'b0, 5);
    wait_for_digests();
  endtask

  task automatic test_random_messages();
    int len, pick;
    while (bytes_sent < TARGET_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(0, 20);
      else if (pick < 18) len = $urandom_range(50, 70);
      else len = $urandom_range(110, 130);
      if ($urandom_range(0, 7) == 0) gaps_on = ~gaps_on;
      run_message(len, 1'($urandom), 10);
      if ($urandom_range(0, 9) == 0) wait_for_digests();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: always ready, coin-flip, or mostly ready with long stalls.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        case (rx_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom);
          default: begin
            pop <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
          end
        endcase
      end
      if ($urandom_range(0, 99) == 0) rx_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    md4_out_t want;
    if (rst_n && pop && !empty) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, got %h/%0d/%b", $time,
                 out_item.digest_word, out_item.word_number, out_item.last_word);
        mismatches++;
      end else begin
        want = digest_queue.pop_front();
        if (out_item.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h, got %h", $time,
                   want.digest_word, out_item.digest_word);
          mismatches++;
        end
        if (out_item.word_number !== want.word_number) begin
          $display("%0t: word_number expected %0d, got %0d", $time,
                   want.word_number, out_item.word_number);
          mismatches++;
        end
        if (out_item.last_word !== want.last_word) begin
          $display("%0t: last_word expected %b, got %b", $time,
                   want.last_word, out_item.last_word);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which no word moves either way.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    clear_chain();
    for (int i = 0; i < 16; i++) block_buf[i] = 32'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_messages();
    test_block_boundaries();
    test_random_messages();

    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
